>>> hdl/xmt_pkg.sv
// Shared types, constants and helper functions of the XML markup tokenizer.
package xmt_pkg;

  localparam int OFFSET_BITS = 32;
  localparam int MAX_DEPTH   = 255;
  localparam int DEPTH_BITS  = $clog2(MAX_DEPTH + 1);
  localparam int OUT_OFFSET_BITS = 32;
  localparam int OUT_DEPTH_BITS  = 8;

  localparam int RESULTS_MAX = 2;
  localparam int FIFO_DEPTH  = 2 * RESULTS_MAX;
  localparam int PTR_BITS    = $clog2(FIFO_DEPTH);
  localparam int LEVEL_BITS  = $clog2(FIFO_DEPTH + 1);
  localparam int COUNT_BITS  = $clog2(RESULTS_MAX + 1);

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QUERY = 8'h3F;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_RSQB  = 8'h5D;

  localparam logic [2:0] CDATA_LAST = 3'd6;

  typedef enum logic [2:0] {
    MODE_TEXT,
    MODE_LT,
    MODE_TAG,
    MODE_BANG,
    MODE_DECL,
    MODE_PI,
    MODE_CLOSE,
    MODE_CDATA
  } scan_mode_t;

  typedef enum logic [2:0] {
    EV_OPEN,
    EV_CLOSE,
    EV_EMPTY,
    EV_DECL,
    EV_PI,
    EV_CDATA,
    EV_END,
    EV_ERR
  } event_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_UNEXPECTED_END,
    ERR_CLOSE_WITHOUT_OPEN,
    ERR_DEPTH_OVERFLOW
  } error_code_t;

  typedef struct packed {
    event_kind_t                  kind;
    logic [OUT_OFFSET_BITS-1:0]   start_offset;
    logic [OUT_OFFSET_BITS-1:0]   end_offset;
    logic [OUT_DEPTH_BITS-1:0]    depth;
    error_code_t                  err;
    logic                         last;
  } event_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] count;
    event_t                ev0;
    event_t                ev1;
  } push_t;

  // Characters that follow "<!" in a CDATA section opener.
  function automatic logic [7:0] cdata_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h5B;
      3'd1:    c = 8'h43;
      3'd2:    c = 8'h44;
      3'd3:    c = 8'h41;
      3'd4:    c = 8'h54;
      3'd5:    c = 8'h41;
      3'd6:    c = 8'h5B;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [OUT_OFFSET_BITS-1:0] out_offset(
    input logic [OFFSET_BITS-1:0] v
  );
    return OUT_OFFSET_BITS'(v);
  endfunction

  function automatic logic [OUT_DEPTH_BITS-1:0] sat_depth(
    input logic [DEPTH_BITS-1:0] d
  );
    logic [OUT_DEPTH_BITS-1:0] r;
    if (32'(d) > 32'd255) begin
      r = '1;
    end else begin
      r = OUT_DEPTH_BITS'(d);
    end
    return r;
  endfunction

endpackage

>>> hdl/xml_markup_tokenizer.sv
// Top level of the XML markup tokenizer.
// The input channel takes one document byte per transaction, with is_final on
// the last byte of a document. The output channel gives one markup event per
// transaction: kind, span offsets, nesting depth after the event, error code
// and a flag on the last event caused by a byte.
// A transaction completes on a rising edge where valid is high and stall is low.
// Each accepted byte is held in an input register and decided in the next
// cycle; its events enter a four-entry result queue at the end of that cycle
// and are registered there before they can be taken. One byte is accepted per
// cycle while in_stall is low. in_stall rises when the queue, counting the
// events of the byte being decided, holds more than two events, which happens
// when the receiver stalls or just after a final byte yields two events; the
// queue drains one event per cycle while out_stall is low.
// A final byte reports any open construct as an error, then a document end
// event, and the scanner starts the next document from offset zero.
// Reset clears the scanner state and empties the queue; there is no clearing
// pass and the first byte may be offered in the cycle after reset.
module xml_markup_tokenizer import xmt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  byte_value,
  input  logic        is_final,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_kind,
  output logic [31:0] start_offset,
  output logic [31:0] end_offset,
  output logic [7:0]  nest_depth,
  output logic [1:0]  error_code,
  output logic        last_of_run
);

  push_t                 push;
  logic [LEVEL_BITS-1:0] level;
  event_t                head;

  xmt_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .byte_value (byte_value),
    .is_final   (is_final),
    .fifo_level (level),
    .push       (push)
  );

  xmt_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .level     (level),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign event_kind   = head.kind;
  assign start_offset = head.start_offset;
  assign end_offset   = head.end_offset;
  assign nest_depth   = head.depth;
  assign error_code   = head.err;
  assign last_of_run  = head.last;

endmodule

>>> hdl/xmt_scan.sv
// Input register and per-byte markup scanner producing up to two events per byte.
module xmt_scan import xmt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            byte_value,
  input  logic                  is_final,
  input  logic [LEVEL_BITS-1:0] fifo_level,
  output push_t                 push
);

  logic                   stg_valid;
  logic [7:0]             stg_byte;
  logic                   stg_fin;

  scan_mode_t             mode, mode_next, mode_step;
  logic [OFFSET_BITS-1:0] pos, pos_next, end_pos;
  logic [OFFSET_BITS-1:0] mstart, mstart_next, mstart_step;
  logic [DEPTH_BITS-1:0]  depth, depth_next, depth_step;
  logic [2:0]             midx, midx_next;
  logic                   slash, slash_next;

  logic                   accept;
  logic                   is_gt;
  logic                   at_max;
  logic                   cdata_hit;
  logic                   pv;
  event_t                 pev, uev, eev;
  logic                   uv;
  logic [LEVEL_BITS:0]    level_ahead;

  assign level_ahead = {1'b0, fifo_level}
                     + {{(LEVEL_BITS+1-COUNT_BITS){1'b0}}, push.count};
  assign in_stall    = level_ahead > (LEVEL_BITS+1)'(FIFO_DEPTH - RESULTS_MAX);
  assign accept      = in_valid && !in_stall;

  assign end_pos   = pos + OFFSET_BITS'(1);
  assign is_gt     = stg_byte == CH_GT;
  assign at_max    = depth >= DEPTH_BITS'(MAX_DEPTH);
  assign cdata_hit = stg_byte == cdata_char(midx);

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
      mode      <= MODE_TEXT;
      pos       <= '0;
      mstart    <= '0;
      depth     <= '0;
      midx      <= '0;
      slash     <= 1'b0;
    end else begin
      stg_valid <= accept;
      mode      <= mode_next;
      pos       <= pos_next;
      mstart    <= mstart_next;
      depth     <= depth_next;
      midx      <= midx_next;
      slash     <= slash_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_byte <= byte_value;
      stg_fin  <= is_final;
    end
  end

  // Next state.
  always_comb begin
    mode_step   = mode;
    mstart_step = mstart;
    depth_step  = depth;
    midx_next   = midx;
    slash_next  = slash;
    pos_next    = pos;
    if (stg_valid) begin
      pos_next = end_pos;
      unique case (mode)
        MODE_TEXT: begin
          if (stg_byte == CH_LT) begin
            mstart_step = pos;
            mode_step   = MODE_LT;
          end
        end
        MODE_LT: begin
          slash_next = 1'b0;
          if (stg_byte == CH_BANG) begin
            mode_step = MODE_BANG;
            midx_next = '0;
          end else if (stg_byte == CH_QUERY) begin
            mode_step = MODE_PI;
          end else if (stg_byte == CH_SLASH) begin
            mode_step = MODE_CLOSE;
          end else if (is_gt) begin
            mode_step = MODE_TEXT;
            if (!at_max) begin
              depth_step = depth + DEPTH_BITS'(1);
            end
          end else begin
            mode_step = MODE_TAG;
          end
        end
        MODE_TAG: begin
          if (is_gt) begin
            if (!slash && !at_max) begin
              depth_step = depth + DEPTH_BITS'(1);
            end
            slash_next = 1'b0;
            mode_step  = MODE_TEXT;
          end else begin
            slash_next = stg_byte == CH_SLASH;
          end
        end
        MODE_BANG: begin
          if (cdata_hit) begin
            if (midx == CDATA_LAST) begin
              midx_next = '0;
              mode_step = MODE_CDATA;
            end else begin
              midx_next = midx + 3'd1;
            end
          end else begin
            midx_next = '0;
            mode_step = is_gt ? MODE_TEXT : MODE_DECL;
          end
        end
        MODE_DECL, MODE_PI: begin
          if (is_gt) begin
            mode_step = MODE_TEXT;
          end
        end
        MODE_CLOSE: begin
          if (is_gt) begin
            if (depth != '0) begin
              depth_step = depth - DEPTH_BITS'(1);
            end
            mode_step = MODE_TEXT;
          end
        end
        MODE_CDATA: begin
          if (stg_byte == CH_RSQB) begin
            midx_next = (midx >= 3'd1) ? 3'd2 : 3'd1;
          end else if (is_gt && midx >= 3'd2) begin
            midx_next = '0;
            mode_step = MODE_TEXT;
          end else begin
            midx_next = '0;
          end
        end
        default: begin
          mode_step = MODE_TEXT;
        end
      endcase
    end

    mode_next   = mode_step;
    mstart_next = mstart_step;
    depth_next  = depth_step;
    if (stg_valid && stg_fin) begin
      mode_next   = MODE_TEXT;
      mstart_next = '0;
      depth_next  = '0;
      midx_next   = '0;
      slash_next  = 1'b0;
      pos_next    = '0;
    end
  end

  // Events.
  always_comb begin
    pv               = 1'b0;
    pev.kind         = EV_OPEN;
    pev.err          = ERR_NONE;
    pev.start_offset = out_offset(mstart);
    pev.end_offset   = out_offset(end_pos);
    pev.depth        = sat_depth(depth_step);
    pev.last         = 1'b0;
    if (stg_valid) begin
      unique case (mode)
        MODE_LT, MODE_TAG: begin
          if (is_gt) begin
            pv = 1'b1;
            if (mode == MODE_TAG && slash) begin
              pev.kind = EV_EMPTY;
            end else if (at_max) begin
              pev.kind = EV_ERR;
              pev.err  = ERR_DEPTH_OVERFLOW;
            end else begin
              pev.kind = EV_OPEN;
            end
          end
        end
        MODE_BANG: begin
          if (!cdata_hit && is_gt) begin
            pv       = 1'b1;
            pev.kind = EV_DECL;
          end
        end
        MODE_DECL: begin
          if (is_gt) begin
            pv       = 1'b1;
            pev.kind = EV_DECL;
          end
        end
        MODE_PI: begin
          if (is_gt) begin
            pv       = 1'b1;
            pev.kind = EV_PI;
          end
        end
        MODE_CLOSE: begin
          if (is_gt) begin
            pv = 1'b1;
            if (depth == '0) begin
              pev.kind = EV_ERR;
              pev.err  = ERR_CLOSE_WITHOUT_OPEN;
            end else begin
              pev.kind = EV_CLOSE;
            end
          end
        end
        MODE_CDATA: begin
          if (is_gt && midx >= 3'd2) begin
            pv       = 1'b1;
            pev.kind = EV_CDATA;
          end
        end
        default: begin
          pv = 1'b0;
        end
      endcase
    end

    uv               = stg_valid && stg_fin && (mode_step != MODE_TEXT);
    uev.kind         = EV_ERR;
    uev.err          = ERR_UNEXPECTED_END;
    uev.start_offset = out_offset(mstart_step);
    uev.end_offset   = out_offset(end_pos);
    uev.depth        = sat_depth(depth_step);
    uev.last         = 1'b0;

    eev.kind         = EV_END;
    eev.err          = ERR_NONE;
    eev.start_offset = '0;
    eev.end_offset   = out_offset(end_pos);
    eev.depth        = sat_depth(depth_step);
    eev.last         = 1'b1;

    push.count = '0;
    push.ev0   = pv ? pev : (uv ? uev : eev);
    push.ev1   = eev;
    if (stg_valid) begin
      if (stg_fin) begin
        push.count = (pv || uv) ? COUNT_BITS'(2) : COUNT_BITS'(1);
      end else if (pv) begin
        push.count   = COUNT_BITS'(1);
        push.ev0.last = 1'b1;
      end
    end
  end

endmodule

>>> hdl/xmt_fifo.sv
// Small result queue that takes up to two events per cycle and delivers one while out_stall is low.
module xmt_fifo import xmt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  push_t                 push,
  output logic [LEVEL_BITS-1:0] level,
  output logic                  out_valid,
  input  logic                  out_stall,
  output event_t                head
);

  event_t                mem [FIFO_DEPTH];
  logic [PTR_BITS-1:0]   wp, wp_next;
  logic [PTR_BITS-1:0]   rp, rp_next;
  logic [LEVEL_BITS-1:0] level_next;
  logic                  pop;

  assign out_valid = level != '0;
  assign pop       = out_valid && !out_stall;
  assign head      = mem[rp];

  always_comb begin
    wp_next    = wp + PTR_BITS'(push.count);
    rp_next    = pop ? rp + PTR_BITS'(1) : rp;
    level_next = level + LEVEL_BITS'(push.count) - LEVEL_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      level <= '0;
    end else begin
      wp    <= wp_next;
      rp    <= rp_next;
      level <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != '0) begin
      mem[wp] <= push.ev0;
    end
    if (push.count == COUNT_BITS'(2)) begin
      mem[PTR_BITS'(wp + PTR_BITS'(1))] <= push.ev1;
    end
  end

endmodule
